[design/rdsc_pkg.sv]
// shared types, constants and the digit glyph function for the radix digit converter
`timescale 1ns / 1ps
package rdsc_pkg;

    // radix register limits and reset value
    localparam int RADIX_W = 5;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // digit and character widths
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int OUT_TDATA_W = 8;

    // status from the divide unit to the sequencer
    typedef struct packed {
        logic done;
        logic quo_zero;
    } t_div_stat;

    // digit value to ascii '0'-'9', 'A'-'F'
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = 7'd48 + {3'b000, d};
        end else begin
            c = 7'd55 + {3'b000, d};
        end
        return c;
    endfunction

endpackage

[design/rdsc_divider.sv]
// shared shift-subtract unit: divides a value by the radix, one quotient bit per cycle
`timescale 1ns / 1ps
module rdsc_divider #(
    parameter int WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [WIDTH-1:0]              i_dividend,
    input  logic [rdsc_pkg::RADIX_W-1:0]  i_base,
    output rdsc_pkg::t_div_stat           o_stat,
    output logic [WIDTH-1:0]              o_quotient,
    output logic [rdsc_pkg::DIGIT_W-1:0]  o_remainder
);
    import rdsc_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [WIDTH-1:0]     r_quo;
    logic [DIGIT_W-1:0]   r_rem;
    logic [RADIX_W-1:0]   r_base;

    logic [RADIX_W-1:0]   w_trial;
    logic                 w_qbit;
    logic [DIGIT_W-1:0]   n_rem;

    // one restoring step: bring down the next bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_quo[WIDTH-1]};
        w_qbit  = (w_trial >= r_base);
        if (w_qbit) begin
            n_rem = DIGIT_W'(w_trial - r_base);
        end else begin
            n_rem = w_trial[DIGIT_W-1:0];
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_base <= i_base;
        end else if (r_busy) begin
            r_quo <= {r_quo[WIDTH-2:0], w_qbit};
            r_rem <= n_rem;
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quo_zero = (r_quo == '0);
    assign o_quotient      = r_quo;
    assign o_remainder     = r_rem;

endmodule

[design/rdsc_digit_mem.sv]
// digit store: one write port, one registered read port
`timescale 1ns / 1ps
module rdsc_digit_mem #(
    parameter int DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [rdsc_pkg::DIGIT_W-1:0]  i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [rdsc_pkg::DIGIT_W-1:0]  o_rd_data
);
    import rdsc_pkg::*;

    logic [DIGIT_W-1:0] r_mem [DEPTH];
    logic [DIGIT_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/radix_digit_string_converter.sv]
// top level: radix register, conversion sequencer and digit output stage
//
// Converts one unsigned number per input beat into its digit string in the
// configured radix (2..16), sent most significant digit first as ascii
// '0'-'9', 'A'-'F', one output beat per digit, tlast on the final digit.
// A zero input gives a single '0' beat with tlast.
// Input: s_axis beats carry the number in tdata. Output: m_axis beats carry
// the character in tdata bits 6:0 and the final-digit mark in tlast.
// Config: i_cfg_wen writes i_cfg_wdata to the radix; values below 2 become 2,
// above 16 become 16. Write only while the block is idle.
// Flow: one number at a time. The shared shift-subtract divider makes the
// digits one by one, least significant first, into the digit store; each
// digit is then read back (S_FETCH) and offered as an output beat (S_SEND),
// which holds until the receiver is ready. s_axis_tready is high only
// between items.
// Reset: synchronous active-low; radix returns to 10, the sequencer to idle.
// Stalls: a digit beat holds on m_axis until taken; nothing else moves.
`timescale 1ns / 1ps
module radix_digit_string_converter #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [rdsc_pkg::RADIX_W-1:0]         i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // fields from bit 0: value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // fields from bit 0: digit_char (7 bits), zero pad bit
    output logic [rdsc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);
    import rdsc_pkg::*;

    localparam int AW = $clog2(VALUE_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_FETCH = 4'b0100,
        S_SEND  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [RADIX_W-1:0]   r_radix;
    logic [AW-1:0]        r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]        r_pos, n_pos;

    logic                 w_accept;
    logic [VALUE_WIDTH-1:0] w_value;
    logic                 w_div_start;
    logic [VALUE_WIDTH-1:0] w_div_dividend;
    t_div_stat            w_div_stat;
    logic [VALUE_WIDTH-1:0] w_quotient;
    logic [DIGIT_W-1:0]   w_remainder;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [DIGIT_W-1:0]   w_wr_data;
    logic [DIGIT_W-1:0]   w_rd_data;

    // radix register with clamping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_wen) begin
            if (i_cfg_wdata < RADIX_MIN) begin
                r_radix <= RADIX_MIN;
            end else if (i_cfg_wdata > RADIX_MAX) begin
                r_radix <= RADIX_MAX;
            end else begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_value         = i_s_axis_tdata[VALUE_WIDTH-1:0];

    // sequencer: divide until the quotient is zero, then read digits back out
    always_comb begin
        n_state        = r_state;
        n_wr_ptr       = r_wr_ptr;
        n_pos          = r_pos;
        w_div_start    = 1'b0;
        w_div_dividend = w_quotient;
        w_wr_en        = 1'b0;
        w_wr_addr      = r_wr_ptr;
        w_wr_data      = w_remainder;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_value == '0) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = '0;
                        n_pos     = '0;
                        n_state   = S_FETCH;
                    end else begin
                        w_div_start    = 1'b1;
                        w_div_dividend = w_value;
                        n_wr_ptr       = '0;
                        n_state        = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    w_wr_en = 1'b1;
                    if (w_div_stat.quo_zero || r_wr_ptr == AW'(VALUE_WIDTH - 1)) begin
                        n_pos   = r_wr_ptr;
                        n_state = S_FETCH;
                    end else begin
                        w_div_start = 1'b1;
                        n_wr_ptr    = r_wr_ptr + 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_m_axis_tready) begin
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos - 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_ptr <= '0;
            r_pos    <= '0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_pos    <= n_pos;
        end
    end

    // shared divide unit
    rdsc_divider #(
        .WIDTH (VALUE_WIDTH)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_base      (r_radix),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    // digit store, least significant digit at address zero
    rdsc_digit_mem #(
        .DEPTH (VALUE_WIDTH)
    ) u_digit_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_pos),
        .o_rd_data (w_rd_data)
    );

    // output beat
    assign o_m_axis_tvalid = (r_state == S_SEND);
    assign o_m_axis_tdata  = {1'b0, digit_glyph(w_rd_data)};
    assign o_m_axis_tlast  = (r_pos == '0);

`ifndef SYNTHESIS
    // never take a new number while a digit is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while digit beat pending");

    // divider completes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // radix register stays within the legal range
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX))
        else $error("radix out of range");

    // the final digit beat returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("not idle after final digit");
`endif

endmodule

[bench/radix_digit_checker.sv]
// checker for the radix digit converter: predicts digit beats and compares them
`timescale 1ns / 1ps
module radix_digit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wen,
    input  logic [rdsc_pkg::RADIX_W-1:0] i_cfg_wdata,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    // fields from bit 0: value
    input  logic [31:0]                  i_s_tdata,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    // fields from bit 0: digit_char (7 bits), zero pad bit
    input  logic [7:0]                   i_m_tdata,
    input  logic                         i_m_tlast,
    output int                           o_errors,
    output int                           o_pending
);
    import rdsc_pkg::*;

    // digit characters indexed by digit value, first character in the top byte
    localparam logic [16*8-1:0] GLYPH_ROM = "0123456789ABCDEF";

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_digit_beat;

    t_digit_beat          digit_q[$];
    logic [RADIX_W-1:0]   base_q;

    // register write: low 5 bits, clamped to the legal radix range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] w);
        logic [RADIX_W-1:0] r;
        r = w;
        if (r < RADIX_MIN) begin
            r = RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [7:0] code;
        code = GLYPH_ROM[8*(15-d) +: 8];
        return code[CHAR_W-1:0];
    endfunction

    // divide down to digits, least significant first, then queue them msd first
    function automatic void queue_digits(input logic [31:0] value);
        logic [DIGIT_W-1:0] rev [0:31];
        logic [31:0]        quo;
        logic [31:0]        rem;
        int                 n;
        t_digit_beat        b;
        quo = value;
        n   = 0;
        if (quo == 32'd0) begin
            rev[0] = '0;
            n      = 1;
        end
        while (quo != 32'd0 && n < 32) begin
            rem    = quo % base_q;
            rev[n] = rem[DIGIT_W-1:0];
            quo    = quo / base_q;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            b.ch   = ascii_of(rev[k]);
            b.last = (k == 0);
            digit_q.push_back(b);
        end
    endfunction

    // compare one output beat with the oldest predicted digit
    task automatic check_beat();
        t_digit_beat want;
        if (digit_q.size() == 0) begin
            $display("%0t: unexpected digit beat, expected none, actual tdata %h tlast %b",
                     $time, i_m_tdata, i_m_tlast);
            o_errors++;
        end else begin
            want = digit_q.pop_front();
            if (i_m_tdata[CHAR_W-1:0] != want.ch) begin
                $display("%0t: digit char mismatch, expected %h actual %h",
                         $time, want.ch, i_m_tdata[CHAR_W-1:0]);
                o_errors++;
            end
            if (i_m_tdata[7] != 1'b0) begin
                $display("%0t: pad bit mismatch, expected 0 actual %b", $time, i_m_tdata[7]);
                o_errors++;
            end
            if (i_m_tlast != want.last) begin
                $display("%0t: last digit mismatch, expected %b actual %b",
                         $time, want.last, i_m_tlast);
                o_errors++;
            end
        end
    endtask

    // sample both channels and the register port at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_q   = RADIX_RESET;
            o_errors = 0;
            digit_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_beat();
            end
            if (i_s_tvalid && i_s_tready) begin
                queue_digits(i_s_tdata);
            end
            if (i_cfg_wen) begin
                base_q = clamp_radix(i_cfg_wdata);
            end
        end
        o_pending = digit_q.size();
    end

endmodule

[bench/radix_digit_string_converter_tb.sv]
// testbench top for the radix digit converter: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
module radix_digit_string_converter_tb;
    import rdsc_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wen;
    logic [RADIX_W-1:0]  i_cfg_wdata;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [31:0]         i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [7:0]          o_m_axis_tdata;
    logic                o_m_axis_tlast;

    int                  fail_cnt;
    int                  digits_owed;
    int                  stall_left;
    logic                idle_off;

    radix_digit_string_converter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    radix_digit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tlast   (o_m_axis_tlast),
        .o_errors    (fail_cnt),
        .o_pending   (digits_owed)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit, well beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("radix_digit_string_converter test failed");
        $finish;
    end

    // receiver: ready, with random stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!idle_off && $urandom_range(0, 5) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // one number beat; valid stays up for a back-to-back beat
    task automatic send_number(input logic [31:0] value);
        int gap;
        gap = 0;
        if (!idle_off && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // take valid down and wait until every predicted digit has come out
    task automatic drain_digits();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= $urandom;
        @(negedge i_clk);
        while (digits_owed != 0) @(negedge i_clk);
    endtask

    // radix write once the converter is idle
    task automatic set_radix(input logic [RADIX_W-1:0] w);
        drain_digits();
        repeat (4) @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        i_cfg_wdata <= RADIX_W'($urandom);
    endtask

    // numbers of varied magnitude and bit pattern
    function automatic logic [31:0] pick_number();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 255);
            2: v = $urandom >> $urandom_range(0, 31);
            3: v = 32'd1 << $urandom_range(0, 31);
            4: v = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            default: v = $urandom_range(0, 20);
        endcase
        return v;
    endfunction

    initial begin
        int n_items;
        i_rst_n         = 1'b0;
        i_cfg_wen       = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        stall_left      = 0;
        idle_off        = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: decimal after reset, zero, single digits, full range
        send_number(32'd0);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'hFFFF_FFFF);
        send_number(32'd1_000_000_000);
        // write below range gives binary, with the 32 digit worst case
        set_radix(5'd0);
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'h5555_5555);
        set_radix(5'd1);
        send_number(32'd6);
        // hexadecimal, with letter digits
        set_radix(RADIX_MAX);
        send_number(32'hFFFF_FFFF);
        send_number(32'hDEAD_BEEF);
        send_number(32'd15);
        send_number(32'd16);
        send_number(32'd0);
        // writes above range give hexadecimal
        set_radix(5'd31);
        send_number(32'h0123_ABCD);
        set_radix(5'd17);
        send_number(32'd255);
        set_radix(5'd3);
        send_number(32'hFFFF_FFFF);
        send_number(32'd2);
        send_number(32'd3);
        set_radix(RADIX_RESET);
        send_number(32'hAAAA_AAAA);

        // random phases, each under its own radix write
        for (int ph = 0; ph < 14; ph++) begin
            if (ph == 13) begin
                idle_off = 1'b1;
            end
            set_radix(RADIX_W'($urandom_range(0, 31)));
            n_items = $urandom_range(14, 20);
            for (int i = 0; i < n_items; i++) begin
                // sender holds off until the output side is empty
                if (ph == 4 && i == n_items / 2) begin
                    drain_digits();
                end
                send_number(pick_number());
            end
        end

        drain_digits();
        repeat (1200) @(negedge i_clk);
        if (fail_cnt == 0 && digits_owed == 0) begin
            $display("radix_digit_string_converter test passed");
        end else begin
            $display("radix_digit_string_converter test failed");
        end
        $finish;
    end

endmodule
